// File: hw/rtl/sktl_pkg.sv
package sktl_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH   = 1024;
	localparam int MAX_KEY_BYTES = 8;
	localparam int KEY_W         = 64;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int CNT_W         = IDX_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_ACCESS_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WIDTH   = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_SORTED = 2'd0,
		MODE_DENSE  = 2'd1,
		MODE_CUSTOM = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_NOT_SORTED  = 3'd1,
		STAT_DENSE_MISM  = 3'd2,
		STAT_UNSUPPORTED = 3'd3,
		STAT_INVALID     = 3'd4,
		STAT_FULL        = 3'd5
	} status_t;

	typedef struct packed {
		mode_t      access_mode;
		logic [3:0] key_width_bytes;
	} cfg_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] slot_index;
		status_t          status;
		logic             batch_end;
	} result_t;

	// A configuration is usable when the width is in range and matches the mode.
	function automatic logic cfg_ok(input cfg_t c);
		logic width_ok;
		width_ok = (c.key_width_bytes != 4'd0) &&
			(c.key_width_bytes <= 4'(MAX_KEY_BYTES));
		case (c.access_mode)
			MODE_SORTED: cfg_ok = width_ok;
			MODE_DENSE:  cfg_ok = width_ok && (c.key_width_bytes == 4'd4);
			MODE_CUSTOM: cfg_ok = width_ok;
			default:     cfg_ok = 1'b0;
		endcase
	endfunction

	// Mask that keeps the low key_width_bytes bytes of a key.
	function automatic logic [KEY_W-1:0] key_mask(input logic [3:0] width_bytes);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEY_W / 8; i++) begin
			m[i*8 +: 8] = (4'(i) < width_bytes) ? 8'hFF : 8'h00;
		end
		key_mask = m;
	endfunction

endpackage

// File: hw/rtl/sktl_engine.sv
module sktl_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  sktl_pkg::cfg_t     cfg,
	input  logic               start,
	input  sktl_pkg::cmd_t     cmd,
	input  logic [63:0]        key,
	input  logic               batch_end,
	output logic               idle,
	output logic               res_valid,
	input  logic               res_take,
	output sktl_pkg::result_t  res
);
	import sktl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_APPEND_CHK,
		S_SEARCH,
		S_MATCH,
		S_DONE
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic             bend_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] mid_q;
	result_t          res_q;

	// Key store: one write port, one registered read port.
	logic [KEY_W-1:0] key_store [TABLE_DEPTH];
	logic [KEY_W-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;

	// Datapath helpers.
	logic [KEY_W-1:0] mask;
	logic [KEY_W-1:0] k;
	logic [KEY_W-1:0] rd_m;
	logic [KEY_W-1:0] cnt_ext;
	logic             cfg_good;
	logic             full;
	logic             gt;
	logic [CNT_W-1:0] lo_n;
	logic [CNT_W-1:0] hi_n;
	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid_n;
	logic             disp_append_ok;
	logic             chk_append_ok;

	assign mask     = key_mask(cfg.key_width_bytes);
	assign k        = key_q & mask;
	assign rd_m     = rd_data_q & mask;
	assign cnt_ext  = KEY_W'(cnt_q);
	assign cfg_good = cfg_ok(cfg);
	assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));

	// One binary search step on the word read for mid_q.
	assign gt      = (k > rd_m);
	assign lo_n    = gt ? (mid_q + CNT_W'(1)) : lo_q;
	assign hi_n    = gt ? hi_q : mid_q;
	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n   = mid_sum[CNT_W:1];

	// Appends that need no stored key, and appends after the order check.
	assign disp_append_ok = (cmd_q == CMD_APPEND) && cfg_good && !full &&
		!((cfg.access_mode == MODE_SORTED) && (cnt_q != '0)) &&
		!((cfg.access_mode == MODE_DENSE) && (k != cnt_ext));
	assign chk_append_ok  = !(rd_m >= k);

	// Memory address and write enable.
	always_comb begin
		wr_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_DISPATCH: begin
				wr_en = disp_append_ok;
				if (cmd_q == CMD_APPEND) begin
					rd_addr = IDX_W'(cnt_q - CNT_W'(1));
				end else begin
					rd_addr = IDX_W'(cnt_q >> 1);
				end
			end
			S_APPEND_CHK: begin
				wr_en = chk_append_ok;
			end
			S_SEARCH: begin
				rd_addr = (lo_n < hi_n) ? IDX_W'(mid_n) : IDX_W'(lo_n);
			end
			default: begin
				wr_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_store[cnt_q[IDX_W-1:0]] <= key_q;
		end
		rd_data_q <= key_store[rd_addr];
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						key_q   <= key;
						bend_q  <= batch_end;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_q.found      <= 1'b0;
					res_q.slot_index <= '1;
					res_q.status     <= STAT_OK;
					res_q.batch_end  <= bend_q;
					state_q          <= S_DONE;
					if (cmd_q == CMD_CLEAR) begin
						cnt_q <= '0;
					end else if (cmd_q == CMD_RSVD || !cfg_good) begin
						res_q.status <= STAT_INVALID;
					end else if (cmd_q == CMD_APPEND) begin
						if (full) begin
							res_q.status <= STAT_FULL;
						end else if (cfg.access_mode == MODE_SORTED && cnt_q != '0) begin
							state_q <= S_APPEND_CHK;
						end else if (cfg.access_mode == MODE_DENSE && k != cnt_ext) begin
							res_q.status <= STAT_DENSE_MISM;
						end else begin
							res_q.slot_index <= cnt_q[IDX_W-1:0];
							cnt_q            <= cnt_q + CNT_W'(1);
						end
					end else if (cfg.access_mode == MODE_CUSTOM) begin
						res_q.status <= STAT_UNSUPPORTED;
					end else if (cfg.access_mode == MODE_DENSE) begin
						if (k < cnt_ext) begin
							res_q.found      <= 1'b1;
							res_q.slot_index <= k[IDX_W-1:0];
						end
					end else if (cnt_q != '0) begin
						lo_q    <= '0;
						hi_q    <= cnt_q;
						mid_q   <= cnt_q >> 1;
						state_q <= S_SEARCH;
					end
				end
				S_APPEND_CHK: begin
					if (chk_append_ok) begin
						res_q.slot_index <= cnt_q[IDX_W-1:0];
						cnt_q            <= cnt_q + CNT_W'(1);
					end else begin
						res_q.status <= STAT_NOT_SORTED;
					end
					state_q <= S_DONE;
				end
				S_SEARCH: begin
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n;
					if (lo_n < hi_n) begin
						state_q <= S_SEARCH;
					end else if (lo_n < cnt_q) begin
						state_q <= S_MATCH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MATCH: begin
					if (rd_m == k) begin
						res_q.found      <= 1'b1;
						res_q.slot_index <= lo_q[IDX_W-1:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// The entry count never passes the table depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// A search step always has a non-empty interval inside the table.
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> (lo_q < hi_q) && (hi_q <= cnt_q) && (mid_q < hi_q))
		else $error("search interval out of range");

	// The final equality probe only reads a filled entry.
	a_match_filled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MATCH |-> lo_q < cnt_q)
		else $error("match probe past the last entry");

	// An accepted word is dispatched on the next cycle.
	a_start_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && start |=> state_q == S_DISPATCH)
		else $error("accepted word not dispatched");

	// Count changes only on a write or a clear.
	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en && !((state_q == S_DISPATCH) && (cmd_q == CMD_CLEAR)) |=> $stable(cnt_q))
		else $error("entry count changed without a write or clear");

endmodule

// File: hw/rtl/sorted_key_table_lookup.sv
// Path from acceptance to result: every command passes S_DISPATCH into S_DONE; a sorted
// append to a non-empty table adds S_APPEND_CHK, and a sorted lookup on a non-empty table
// adds an S_SEARCH pass per probe and, if it ends on a filled entry, the S_MATCH compare.
// One word is processed at a time: the next is accepted only after the output register
// takes the result. The search makes one probe per cycle on the memory's single read port.
// Reset empties the table and sets sorted mode with 4-byte keys; no clearing pass.
module sorted_key_table_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sktl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sktl_pkg::CFG_DAT_W-1:0]      cfg_data,
	// Command channel.
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic [63:0]                         key,
	input  logic                                batch_end,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic [sktl_pkg::IDX_W-1:0]          slot_index,
	output logic [2:0]                          status,
	output logic                                batch_end_out
);
	import sktl_pkg::*;

	cfg_t    cfg_q;
	logic    eng_idle;
	logic    eng_res_valid;
	result_t eng_res;
	logic    res_load;
	logic    out_valid_q;
	result_t out_q;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.access_mode     <= MODE_SORTED;
			cfg_q.key_width_bytes <= 4'd4;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ACCESS_MODE) begin
				cfg_q.access_mode <= mode_t'(cfg_data[1:0]);
			end else if (cfg_index == REG_KEY_WIDTH) begin
				cfg_q.key_width_bytes <= cfg_data;
			end
		end
	end

	// Command words enter the engine only while it is idle.
	assign in_stall = !eng_idle;

	sktl_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_valid && !in_stall),
		.cmd       (cmd_t'(cmd)),
		.key       (key),
		.batch_end (batch_end),
		.idle      (eng_idle),
		.res_valid (eng_res_valid),
		.res_take  (res_load),
		.res       (eng_res)
	);

	// Output register: loads when empty or when its word leaves this cycle.
	assign res_load = eng_res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
				out_q       <= eng_res;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = out_q.found;
	assign slot_index    = out_q.slot_index;
	assign status        = out_q.status;
	assign batch_end_out = out_q.batch_end;

endmodule
